@@ hdl/mrle_pkg.sv @@
// Shared types and codes for the mouse report to legacy event translator.
// Used by the sequencer, the datapath and the output stage; no dependencies.
`default_nettype none

package mrle_pkg;

    localparam int PcW = 5;
    typedef logic [PcW-1:0] pc_t;

    // datapath operations carried in the control word
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_IDLE   = 3'd1;
    localparam logic [2:0] OP_FLAGS  = 3'd2;
    localparam logic [2:0] OP_WDEC   = 3'd3;
    localparam logic [2:0] OP_COMMIT = 3'd4;
    localparam logic [2:0] OP_DONE   = 3'd5;

    // emit conditions
    localparam logic [3:0] C_NEVER   = 4'd0;
    localparam logic [3:0] C_B3_RISE = 4'd1;
    localparam logic [3:0] C_B3_FALL = 4'd2;
    localparam logic [3:0] C_B4_RISE = 4'd3;
    localparam logic [3:0] C_B4_FALL = 4'd4;
    localparam logic [3:0] C_B5_RISE = 4'd5;
    localparam logic [3:0] C_B5_FALL = 4'd6;
    localparam logic [3:0] C_ALWAYS  = 4'd7;
    localparam logic [3:0] C_OLD_NEG = 4'd8;
    localparam logic [3:0] C_OLD_POS = 4'd9;
    localparam logic [3:0] C_NEW_POS = 4'd10;
    localparam logic [3:0] C_NEW_NEG = 4'd11;
    localparam logic [3:0] C_MOUSE   = 4'd12;

    // code byte source
    localparam logic [1:0] CS_LIT    = 2'd0;
    localparam logic [1:0] CS_WPRESS = 2'd1;
    localparam logic [1:0] CS_WREL   = 2'd2;
    localparam logic [1:0] CS_HDR    = 2'd3;

    // jump conditions
    localparam logic [1:0] J_NONE   = 2'd0;
    localparam logic [1:0] J_ALWAYS = 2'd1;
    localparam logic [1:0] J_NOGO   = 2'd2;
    localparam logic [1:0] J_WZERO  = 2'd3;

    // report status codes
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_VALID = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WHEEL_WIN = 2'd0;
    localparam logic [1:0] REG_IDLE_DIV  = 2'd1;
    localparam logic [1:0] REG_MAX_KEYS  = 2'd2;

    localparam logic [3:0] WHEEL_WIN_RST = 4'd10;
    localparam logic [3:0] IDLE_DIV_RST  = 4'd3;
    localparam logic [3:0] MAX_KEYS_RST  = 4'd6;
    localparam logic [3:0] WHEEL_CAP     = 4'd8;

    // scancodes
    localparam logic [7:0] SC_ENTER_P  = 8'h72;
    localparam logic [7:0] SC_ENTER_R  = 8'hF2;
    localparam logic [7:0] SC_SHIFT_P  = 8'h2A;
    localparam logic [7:0] SC_SHIFT_R  = 8'hAA;
    localparam logic [7:0] SC_UP_P     = 8'h48;
    localparam logic [7:0] SC_UP_R     = 8'hC8;
    localparam logic [7:0] SC_DOWN_P   = 8'h50;
    localparam logic [7:0] SC_DOWN_R   = 8'hD0;
    localparam logic [7:0] SC_LEFT_P   = 8'h4B;
    localparam logic [7:0] SC_LEFT_R   = 8'hCB;
    localparam logic [7:0] SC_RIGHT_P  = 8'h4D;
    localparam logic [7:0] SC_RIGHT_R  = 8'hCD;
    localparam logic [7:0] CH_ENTER    = 8'h0D;
    localparam logic [7:0] CH_NONE     = 8'h00;
    localparam logic [5:0] PKT_HDR_TOP = 6'b111110;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] cond;
        logic [1:0] csel;
        logic [7:0] code;
        logic [7:0] chr;
        logic [1:0] jmp;
        pc_t        target;
    } uword_t;

    typedef struct packed {
        logic go;
        logic wzero;
    } dp_stat_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic [7:0] chr;
        logic [7:0] dx;
        logic [7:0] dy;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/mouse_report_to_legacy_events.sv @@
// Top level of the mouse report to legacy event translator.
// Instantiates mrle_seq, mrle_dp and mrle_out; depends on mrle_pkg.
//
//  channel  dir  beat contents
//  s_*      in   tuser: report_status; tdata: buttons, move_x, move_y, wheel, pan
//  m_*      out  tuser: event_kind; tdata: code_byte, key_char, packet_dx, packet_dy;
//                tlast: last
//  cfg_*    in   write enable, register index, 4-bit value
//
// The microcode sequencer runs one program step per cycle unless the output
// stage stalls it; a report whose tick ends early jumps to the final step, else
// it runs the whole program with n wheel key pairs (at most 8). A beat is accepted only while
// the sequencer is idle. Results leave through an output register; a full,
// stalled output register holds the sequencer on its next emitting step or
// on its final step while a result is still held.
// Reset restores the register defaults and the saved mouse state.
`default_nettype none

module mouse_report_to_legacy_events (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // buttons, move_x, move_y, wheel, pan
    input  wire logic [1:0]  s_tuser,   // report_status
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // code_byte, key_char, packet_dx, packet_dy
    output logic             m_tuser,   // event_kind
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);
    import mrle_pkg::*;

    uword_t   ctl;
    dp_stat_t stat;
    res_t     res;
    logic     idle;
    logic     step_en;
    logic     stall;
    logic     emit;
    logic     load;

    assign s_tready = idle;
    assign load     = s_tvalid && idle;

    mrle_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (s_tvalid),
        .stall   (stall),
        .stat    (stat),
        .idle    (idle),
        .step_en (step_en),
        .ctl     (ctl)
    );

    mrle_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .report_status (s_tuser),
        .buttons       (s_tdata[15:0]),
        .move_x        (s_tdata[31:16]),
        .move_y        (s_tdata[47:32]),
        .wheel         (s_tdata[55:48]),
        .pan           (s_tdata[63:56]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ctl           (ctl),
        .step_en       (step_en),
        .stat          (stat),
        .emit          (emit),
        .res           (res)
    );

    mrle_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (step_en),
        .emit     (emit),
        .flush    (ctl.op == OP_DONE),
        .res      (res),
        .stall    (stall),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ hdl/mrle_seq.sv @@
// Microcode sequencer: step counter, control store and jump logic.
// Depends on mrle_pkg.
`default_nettype none

module mrle_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              stall,
    input  wire mrle_pkg::dp_stat_t stat,
    output logic                   idle,
    output logic                   step_en,
    output mrle_pkg::uword_t       ctl
);
    import mrle_pkg::*;

    localparam pc_t S_WTEST = pc_t'(12);
    localparam pc_t S_PAN   = pc_t'(15);
    localparam pc_t S_DONE  = pc_t'(20);

    logic busy_reg, busy_next;
    pc_t  pc_reg, pc_next;
    logic taken;

    function automatic uword_t uw(input logic [2:0] op, input logic [3:0] cond,
                                  input logic [1:0] csel, input logic [7:0] code,
                                  input logic [7:0] chr, input logic [1:0] jmp,
                                  input pc_t target);
        uword_t w;
        w.op     = op;
        w.cond   = cond;
        w.csel   = csel;
        w.code   = code;
        w.chr    = chr;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        unique case (pc)
            pc_t'(0):  w = uw(OP_IDLE, C_NEVER, CS_LIT, CH_NONE, CH_NONE, J_NOGO, S_DONE);
            pc_t'(1):  w = uw(OP_FLAGS, C_NEVER, CS_LIT, CH_NONE, CH_NONE, J_NONE, S_DONE);
            pc_t'(2):  w = uw(OP_NONE, C_B3_RISE, CS_LIT, SC_ENTER_P, CH_ENTER, J_NONE, S_DONE);
            pc_t'(3):  w = uw(OP_NONE, C_B3_FALL, CS_LIT, SC_ENTER_R, CH_ENTER, J_NONE, S_DONE);
            pc_t'(4):  w = uw(OP_NONE, C_B4_RISE, CS_LIT, SC_SHIFT_P, CH_NONE, J_NONE, S_DONE);
            pc_t'(5):  w = uw(OP_NONE, C_B4_RISE, CS_LIT, SC_DOWN_P, CH_NONE, J_NONE, S_DONE);
            pc_t'(6):  w = uw(OP_NONE, C_B4_FALL, CS_LIT, SC_DOWN_R, CH_NONE, J_NONE, S_DONE);
            pc_t'(7):  w = uw(OP_NONE, C_B4_FALL, CS_LIT, SC_SHIFT_R, CH_NONE, J_NONE, S_DONE);
            pc_t'(8):  w = uw(OP_NONE, C_B5_RISE, CS_LIT, SC_SHIFT_P, CH_NONE, J_NONE, S_DONE);
            pc_t'(9):  w = uw(OP_NONE, C_B5_RISE, CS_LIT, SC_UP_P, CH_NONE, J_NONE, S_DONE);
            pc_t'(10): w = uw(OP_NONE, C_B5_FALL, CS_LIT, SC_UP_R, CH_NONE, J_NONE, S_DONE);
            pc_t'(11): w = uw(OP_NONE, C_B5_FALL, CS_LIT, SC_SHIFT_R, CH_NONE, J_NONE, S_DONE);
            pc_t'(12): w = uw(OP_NONE, C_NEVER, CS_LIT, CH_NONE, CH_NONE, J_WZERO, S_PAN);
            pc_t'(13): w = uw(OP_NONE, C_ALWAYS, CS_WPRESS, CH_NONE, CH_NONE, J_NONE, S_DONE);
            pc_t'(14): w = uw(OP_WDEC, C_ALWAYS, CS_WREL, CH_NONE, CH_NONE, J_ALWAYS, S_WTEST);
            pc_t'(15): w = uw(OP_NONE, C_OLD_NEG, CS_LIT, SC_LEFT_R, CH_NONE, J_NONE, S_DONE);
            pc_t'(16): w = uw(OP_NONE, C_OLD_POS, CS_LIT, SC_RIGHT_R, CH_NONE, J_NONE, S_DONE);
            pc_t'(17): w = uw(OP_NONE, C_NEW_POS, CS_LIT, SC_RIGHT_P, CH_NONE, J_NONE, S_DONE);
            pc_t'(18): w = uw(OP_NONE, C_NEW_NEG, CS_LIT, SC_LEFT_P, CH_NONE, J_NONE, S_DONE);
            pc_t'(19): w = uw(OP_COMMIT, C_MOUSE, CS_HDR, CH_NONE, CH_NONE, J_NONE, S_DONE);
            default:   w = uw(OP_DONE, C_NEVER, CS_LIT, CH_NONE, CH_NONE, J_NONE, S_DONE);
        endcase
        return w;
    endfunction

    assign ctl     = ucode(pc_reg);
    assign idle    = !busy_reg;
    assign step_en = busy_reg && !stall;

    always_comb
    begin
        unique case (ctl.jmp)
            J_ALWAYS: taken = 1'b1;
            J_NOGO:   taken = !stat.go;
            J_WZERO:  taken = stat.wzero;
            default:  taken = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (step_en)
        begin
            if (ctl.op == OP_DONE)
                busy_next = 1'b0;
            else if (taken)
                pc_next = ctl.target;
            else
                pc_next = pc_reg + pc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mrle_dp.sv @@
// Datapath: settings, latched report, saved mouse state, change flags,
// wheel repeat counter and result assembly. Depends on mrle_pkg.
`default_nettype none

module mrle_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic [1:0]         report_status,
    input  wire logic [15:0]        buttons,
    input  wire logic signed [15:0] move_x,
    input  wire logic signed [15:0] move_y,
    input  wire logic signed [7:0]  wheel,
    input  wire logic signed [7:0]  pan,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [3:0]         cfg_data,
    input  wire mrle_pkg::uword_t   ctl,
    input  wire logic               step_en,
    output mrle_pkg::dp_stat_t      stat,
    output logic                    emit,
    output mrle_pkg::res_t          res
);
    import mrle_pkg::*;

    logic [3:0] win_reg, div_reg, maxk_reg;

    logic [1:0]         status_reg;
    logic [15:0]        btn_reg;
    logic signed [15:0] mx_reg, my_reg;
    logic signed [7:0]  wh_reg, pn_reg;

    logic [15:0] prev_btn_reg, prev_btn_next;
    logic [7:0]  prev_pan_reg, prev_pan_next;
    logic [3:0]  age_reg, age_next;
    logic [3:0]  idle_reg, idle_next;
    logic        saver_reg, saver_next;
    logic        mouse_reg, mouse_next;
    logic        wchg;
    logic        pan_reg, pan_next;
    logic [3:0]  wcnt_reg, wcnt_next;

    logic               below_div;
    logic               skip;
    logic signed [5:0]  factor;
    logic signed [13:0] prod;
    logic [12:0]        mag;
    logic [3:0]         cap;
    logic [3:0]         wcount;
    logic               any_chg;

    function automatic logic [7:0] clip8(input logic signed [15:0] v);
        logic [7:0] r;
        if (v > 16'sd127)
            r = 8'h7F;
        else if (v < -16'sd128)
            r = 8'h80;
        else
            r = v[7:0];
        return r;
    endfunction

    assign below_div = idle_reg < div_reg;
    assign skip      = below_div && saver_reg;

    assign stat.go    = (status_reg == ST_VALID) && !skip;
    assign stat.wzero = wcnt_reg == 4'd0;

    // repeat count: |(window - age + 1) * wheel|, capped
    assign factor  = $signed({2'b00, win_reg}) - $signed({2'b00, age_reg}) + 6'sd1;
    assign prod    = 14'(factor) * 14'(wh_reg);
    assign mag     = prod[13] ? 13'(-prod) : 13'(prod);
    assign cap     = (maxk_reg > WHEEL_CAP) ? WHEEL_CAP : maxk_reg;
    assign wcount  = (mag > 13'(cap)) ? cap : mag[3:0];

    assign mouse_next = (btn_reg != prev_btn_reg) || (mx_reg != 16'sd0) || (my_reg != 16'sd0);
    assign wchg       = wh_reg != 8'sd0;
    assign pan_next   = pn_reg != $signed(prev_pan_reg);
    assign any_chg    = mouse_next || wchg || pan_next;

    always_comb
    begin
        prev_btn_next = prev_btn_reg;
        prev_pan_next = prev_pan_reg;
        age_next      = age_reg;
        idle_next     = idle_reg;
        saver_next    = saver_reg;
        wcnt_next     = wcnt_reg;
        if (step_en)
        begin
            unique case (ctl.op)
                OP_IDLE:
                begin
                    if (status_reg != ST_NONE)
                    begin
                        if (below_div)
                        begin
                            idle_next = idle_reg + 4'd1;
                        end
                        else
                        begin
                            idle_next  = 4'd0;
                            saver_next = 1'b1;
                        end
                        if (!skip && (age_reg < win_reg))
                            age_next = age_reg + 4'd1;
                    end
                end
                OP_FLAGS:
                begin
                    if (any_chg)
                    begin
                        saver_next = 1'b0;
                        idle_next  = 4'd0;
                    end
                    if (wchg)
                        age_next = 4'd0;
                    wcnt_next = wchg ? wcount : 4'd0;
                end
                OP_WDEC:
                begin
                    wcnt_next = wcnt_reg - 4'd1;
                end
                OP_COMMIT:
                begin
                    if (mouse_reg)
                        prev_btn_next = btn_reg;
                    if (pan_reg)
                        prev_pan_next = pn_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= WHEEL_WIN_RST;
            div_reg      <= IDLE_DIV_RST;
            maxk_reg     <= MAX_KEYS_RST;
            prev_btn_reg <= '0;
            prev_pan_reg <= '0;
            age_reg      <= '0;
            idle_reg     <= '0;
            saver_reg    <= 1'b1;
            mouse_reg    <= 1'b0;
            pan_reg      <= 1'b0;
            wcnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WHEEL_WIN: win_reg  <= cfg_data;
                    REG_IDLE_DIV:  div_reg  <= cfg_data;
                    REG_MAX_KEYS:  maxk_reg <= cfg_data;
                    default:       ;
                endcase
            end
            prev_btn_reg <= prev_btn_next;
            prev_pan_reg <= prev_pan_next;
            age_reg      <= age_next;
            idle_reg     <= idle_next;
            saver_reg    <= saver_next;
            wcnt_reg     <= wcnt_next;
            if (step_en && (ctl.op == OP_FLAGS))
            begin
                mouse_reg <= mouse_next;
                pan_reg   <= pan_next;
            end
        end
    end

    // hold the report for the whole program
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= report_status;
            btn_reg    <= buttons;
            mx_reg     <= move_x;
            my_reg     <= move_y;
            wh_reg     <= wheel;
            pn_reg     <= pan;
        end
    end

    always_comb
    begin
        unique case (ctl.cond)
            C_B3_RISE: emit = mouse_reg && btn_reg[2] && !prev_btn_reg[2];
            C_B3_FALL: emit = mouse_reg && !btn_reg[2] && prev_btn_reg[2];
            C_B4_RISE: emit = mouse_reg && btn_reg[3] && !prev_btn_reg[3];
            C_B4_FALL: emit = mouse_reg && !btn_reg[3] && prev_btn_reg[3];
            C_B5_RISE: emit = mouse_reg && btn_reg[4] && !prev_btn_reg[4];
            C_B5_FALL: emit = mouse_reg && !btn_reg[4] && prev_btn_reg[4];
            C_ALWAYS:  emit = 1'b1;
            C_OLD_NEG: emit = pan_reg && prev_pan_reg[7];
            C_OLD_POS: emit = pan_reg && !prev_pan_reg[7] && (prev_pan_reg != 8'd0);
            C_NEW_POS: emit = pan_reg && !pn_reg[7] && (pn_reg != 8'sd0);
            C_NEW_NEG: emit = pan_reg && pn_reg[7];
            C_MOUSE:   emit = mouse_reg;
            default:   emit = 1'b0;
        endcase
    end

    always_comb
    begin
        res.kind = ctl.csel == CS_HDR;
        res.chr  = ctl.chr;
        res.dx   = 8'd0;
        res.dy   = 8'd0;
        unique case (ctl.csel)
            CS_WPRESS: res.code = wh_reg[7] ? SC_DOWN_P : SC_UP_P;
            CS_WREL:   res.code = wh_reg[7] ? SC_DOWN_R : SC_UP_R;
            CS_HDR:
            begin
                res.code = {PKT_HDR_TOP, btn_reg[0], btn_reg[1]};
                res.dx   = clip8(mx_reg);
                res.dy   = clip8(my_reg);
            end
            default:   res.code = ctl.code;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/mrle_out.sv @@
// Output stage: one held result plus the output register, so the final
// beat of a tick can be marked last. Depends on mrle_pkg.
`default_nettype none

module mrle_out (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           emit,
    input  wire logic           flush,
    input  wire mrle_pkg::res_t res,
    output logic                stall,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import mrle_pkg::*;

    logic hold_v_reg, hold_v_next;
    logic out_v_reg, out_v_next;
    res_t hold_reg;
    res_t out_reg;
    logic last_reg;
    logic push;

    // a new result or the end of the program pushes the held one out
    assign stall = hold_v_reg && (emit || flush) && out_v_reg && !m_tready;
    assign push  = adv && hold_v_reg && (emit || flush);

    always_comb
    begin
        out_v_next = out_v_reg;
        if (push)
            out_v_next = 1'b1;
        else if (out_v_reg && m_tready)
            out_v_next = 1'b0;

        hold_v_next = hold_v_reg;
        if (adv && emit)
            hold_v_next = 1'b1;
        else if (adv && flush)
            hold_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
            hold_reg <= res;
        if (push)
        begin
            out_reg  <= hold_reg;
            last_reg <= flush;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.dy, out_reg.dx, out_reg.chr, out_reg.code};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

@@ sim/tb_mouse_report_to_legacy_events.sv @@
// Self-checking bench for mouse_report_to_legacy_events: poll ticks go in on
// the s_* stream and every key event and mouse packet on m_* is checked.
// Depends on mrle_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_mouse_report_to_legacy_events;

    import mrle_pkg::*;

    localparam logic [1:0] ST_FAILED      = 2'd1;
    localparam logic [1:0] ST_ODD         = 2'd3;
    localparam logic       KIND_KEY       = 1'b0;
    localparam logic       KIND_PACKET    = 1'b1;
    localparam int         SETTLE_CYCLES  = 60;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         NUM_PHASES     = 5;
    localparam int         ITEMS_PER_PHASE = 30;
    localparam int         HOLD_AT        = 130;
    localparam int         DIRECTED_N     = 22;

    typedef struct {
        logic [1:0]         status;
        logic [15:0]        buttons;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic signed [7:0]  wheel;
        logic signed [7:0]  pan;
        logic               typed;
        logic               has_packet;
        logic [7:0]         hdr;
        logic [7:0]         dx;
        logic [7:0]         dy;
    } tick_report_t;

    typedef struct {
        logic       kind;
        logic [7:0] code;
        logic [7:0] chr;
        logic [7:0] dx;
        logic [7:0] dy;
        logic       tick_end;
    } legacy_evt_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // buttons, move_x, move_y, wheel, pan
    logic [1:0]  s_tuser;   // report_status
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // code_byte, key_char, packet_dx, packet_dy
    logic        m_tuser;   // event_kind
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    // translator state as the bench sees it
    logic [3:0]        accel_window;
    logic [3:0]        idle_divider;
    logic [3:0]        max_keys;
    logic [15:0]       seen_buttons;
    logic signed [7:0] seen_pan;
    logic [3:0]        wheel_age;
    logic [3:0]        idle_count;
    logic              saver_on;

    legacy_evt_t  pending_events[$];
    tick_report_t directed_rows [DIRECTED_N];

    logic [3:0] phase_win [NUM_PHASES] = '{4'd15, 4'd1, 4'd0, 4'd7, 4'd15};
    logic [3:0] phase_div [NUM_PHASES] = '{4'd0, 4'd2, 4'd15, 4'd1, 4'd0};
    logic [3:0] phase_max [NUM_PHASES] = '{4'd15, 4'd8, 4'd0, 4'd9, 4'd8};

    int send_idle_pct;
    int recv_idle_pct;
    int reports_sent;
    int events_checked;
    int mismatch_count;
    int hold_left;
    logic hold_off_req;
    logic hold_off_taken;

    mouse_report_to_legacy_events dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic legacy_evt_t key_evt(input logic [7:0] code, input logic [7:0] chr);
        legacy_evt_t e;
        e.kind = KIND_KEY;
        e.code = code;
        e.chr = chr;
        e.dx = 8'd0;
        e.dy = 8'd0;
        e.tick_end = 1'b0;
        return e;
    endfunction

    function automatic logic [7:0] clip_motion(input logic signed [15:0] v);
        if (v > 127)
            return 8'h7F;
        if (v < -128)
            return 8'h80;
        return v[7:0];
    endfunction

    // Work out the events one tick causes and advance the saved state.
    function automatic void translate_report(input tick_report_t r, ref legacy_evt_t evts[$]);
        logic signed [7:0] old_pan;
        logic [15:0]       ob;
        logic              mouse_chg;
        logic              wheel_chg;
        logic              pan_chg;
        int                reps;
        int                cap;
        legacy_evt_t       pkt;
        old_pan = seen_pan;
        ob = seen_buttons;
        evts.delete();
        if (r.status == ST_NONE)
            return;
        if (idle_count < idle_divider)
        begin
            idle_count = idle_count + 4'd1;
            if (saver_on)
                return;
        end
        else
        begin
            idle_count = 4'd0;
            saver_on = 1'b1;
        end
        if (wheel_age < accel_window)
            wheel_age = wheel_age + 4'd1;
        if (r.status != ST_VALID)
            return;

        mouse_chg = (r.buttons != ob) || (r.move_x != 0) || (r.move_y != 0);
        wheel_chg = (r.wheel != 0);
        pan_chg = (r.pan != old_pan);

        if (mouse_chg)
        begin
            if (r.buttons[2] && !ob[2])
                evts.push_back(key_evt(SC_ENTER_P, CH_ENTER));
            else if (!r.buttons[2] && ob[2])
                evts.push_back(key_evt(SC_ENTER_R, CH_ENTER));
            if (r.buttons[3] && !ob[3])
            begin
                evts.push_back(key_evt(SC_SHIFT_P, CH_NONE));
                evts.push_back(key_evt(SC_DOWN_P, CH_NONE));
            end
            else if (!r.buttons[3] && ob[3])
            begin
                evts.push_back(key_evt(SC_DOWN_R, CH_NONE));
                evts.push_back(key_evt(SC_SHIFT_R, CH_NONE));
            end
            if (r.buttons[4] && !ob[4])
            begin
                evts.push_back(key_evt(SC_SHIFT_P, CH_NONE));
                evts.push_back(key_evt(SC_UP_P, CH_NONE));
            end
            else if (!r.buttons[4] && ob[4])
            begin
                evts.push_back(key_evt(SC_UP_R, CH_NONE));
                evts.push_back(key_evt(SC_SHIFT_R, CH_NONE));
            end
        end

        if (wheel_chg)
        begin
            // a window lowered below the age gives a zero or negative factor
            reps = (int'(accel_window) - int'(wheel_age) + 1) * int'(r.wheel);
            cap = (max_keys > WHEEL_CAP) ? int'(WHEEL_CAP) : int'(max_keys);
            if (reps < 0)
                reps = -reps;
            if (reps > cap)
                reps = cap;
            repeat (reps)
            begin
                if (r.wheel > 0)
                begin
                    evts.push_back(key_evt(SC_UP_P, CH_NONE));
                    evts.push_back(key_evt(SC_UP_R, CH_NONE));
                end
                else
                begin
                    evts.push_back(key_evt(SC_DOWN_P, CH_NONE));
                    evts.push_back(key_evt(SC_DOWN_R, CH_NONE));
                end
            end
            wheel_age = 4'd0;
        end

        if (pan_chg)
        begin
            if (old_pan < 0)
                evts.push_back(key_evt(SC_LEFT_R, CH_NONE));
            else if (old_pan > 0)
                evts.push_back(key_evt(SC_RIGHT_R, CH_NONE));
            if (r.pan > 0)
                evts.push_back(key_evt(SC_RIGHT_P, CH_NONE));
            else if (r.pan < 0)
                evts.push_back(key_evt(SC_LEFT_P, CH_NONE));
        end

        if (mouse_chg || wheel_chg || pan_chg)
        begin
            saver_on = 1'b0;
            idle_count = 4'd0;
        end

        if (mouse_chg)
        begin
            pkt.kind = KIND_PACKET;
            pkt.code = {PKT_HDR_TOP, r.buttons[0], r.buttons[1]};
            pkt.chr = CH_NONE;
            pkt.dx = clip_motion(r.move_x);
            pkt.dy = clip_motion(r.move_y);
            pkt.tick_end = 1'b0;
            evts.push_back(pkt);
            seen_buttons = r.buttons;
        end

        if (pan_chg)
            seen_pan = r.pan;

        if (evts.size() > 0)
            evts[evts.size() - 1].tick_end = 1'b1;
    endfunction

    function automatic logic [15:0] pick_motion();
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'd0;
            3:       return 16'($urandom_range(0, 10) - 5);
            4:       return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'h8000 + 16'($urandom_range(0, 3))
                                                  : 16'h7FFF - 16'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic offer_report(input tick_report_t r);
        legacy_evt_t evts[$];
        legacy_evt_t pkt;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = r.status;
        s_tdata = {r.pan, r.wheel, r.move_y, r.move_x, r.buttons};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        translate_report(r, evts);
        // hand-written rows replace the predicted beats
        if (r.typed)
        begin
            evts.delete();
            if (r.has_packet)
            begin
                pkt.kind = KIND_PACKET;
                pkt.code = r.hdr;
                pkt.chr = CH_NONE;
                pkt.dx = r.dx;
                pkt.dy = r.dy;
                pkt.tick_end = 1'b1;
                evts.push_back(pkt);
            end
        end
        foreach (evts[i])
            pending_events.push_back(evts[i]);
        reports_sent++;
    endtask

    // Drop valid, let every expected beat arrive, then let the sequencer settle.
    task automatic drain_block();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        case (idx)
            REG_WHEEL_WIN: accel_window = val;
            REG_IDLE_DIV:  idle_divider = val;
            REG_MAX_KEYS:  max_keys = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [3:0] win, input logic [3:0] div,
                                 input logic [3:0] cap);
        write_reg(REG_WHEEL_WIN, win);
        write_reg(REG_IDLE_DIV, div);
        write_reg(REG_MAX_KEYS, cap);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_req && !hold_off_taken)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
            m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        legacy_evt_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            events_checked++;
            if (pending_events.size() == 0)
                report_mismatch("beat with nothing expected", m_tdata, 32'd0);
            else
            begin
                want = pending_events.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("event_kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[7:0] !== want.code)
                    report_mismatch("code_byte", 32'(m_tdata[7:0]), 32'(want.code));
                if (m_tdata[15:8] !== want.chr)
                    report_mismatch("key_char", 32'(m_tdata[15:8]), 32'(want.chr));
                if (m_tdata[23:16] !== want.dx)
                    report_mismatch("packet_dx", 32'(m_tdata[23:16]), 32'(want.dx));
                if (m_tdata[31:24] !== want.dy)
                    report_mismatch("packet_dy", 32'(m_tdata[31:24]), 32'(want.dy));
                if (m_tlast !== want.tick_end)
                    report_mismatch("last", 32'(m_tlast), 32'(want.tick_end));
            end
        end
    end

    initial
    begin
        #800000;
        $display("timeout with %0d events still expected", pending_events.size());
        $display("mouse_report_to_legacy_events: mismatch");
        $finish;
    end

    initial
    begin
        tick_report_t r;
        int idx;
        int rnd;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 64'd0;
        s_tuser = ST_NONE;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WHEEL_WIN;
        cfg_data = 4'd0;
        accel_window = WHEEL_WIN_RST;
        idle_divider = IDLE_DIV_RST;
        max_keys = MAX_KEYS_RST;
        seen_buttons = 16'd0;
        seen_pan = 8'sd0;
        wheel_age = 4'd0;
        idle_count = 4'd0;
        saver_on = 1'b1;
        reports_sent = 0;
        events_checked = 0;
        mismatch_count = 0;
        hold_left = 0;
        hold_off_req = 1'b0;
        hold_off_taken = 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 52;

        // status, buttons, move_x, move_y, wheel, pan, typed, has_packet, hdr, dx, dy
        directed_rows = '{
            // saver swallows the first ticks after reset
            '{ST_VALID,  16'h0001, 16'sd5,   16'sd0,   8'sd0,   8'sd0,   1'b1, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_NONE,   16'hFFFF, 16'h7FFF, 16'h8000, 8'h7F,   8'h80,   1'b1, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0001, 16'sd5,   16'sd0,   8'sd0,   8'sd0,   1'b1, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_FAILED, 16'h0001, 16'sd5,   16'sd0,   8'sd0,   8'sd0,   1'b1, 1'b0,
              8'h00, 8'h00, 8'h00},
            // motion extremes clip to the packet range
            '{ST_VALID,  16'h0003, 16'h7FFF, 16'h8000, 8'sd0,   8'sd0,   1'b1, 1'b1,
              8'hFB, 8'h7F, 8'h80},
            '{ST_VALID,  16'h0003, 16'h8000, 16'h7FFF, 8'sd0,   8'sd0,   1'b1, 1'b1,
              8'hFB, 8'h80, 8'h7F},
            '{ST_ODD,    16'h0003, 16'sd0,   16'sd0,   8'sd5,   8'sd17,  1'b1, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0000, 16'sd0,   16'sd0,   8'sd0,   8'sd0,   1'b1, 1'b1,
              8'hF8, 8'h00, 8'h00},
            '{ST_VALID,  16'h0000, 16'sd0,   16'sd0,   8'sd0,   8'sd0,   1'b1, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0004, 16'sd1,   -16'sd1,  8'sd0,   8'sd0,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h001C, 16'sd0,   16'sd0,   8'sd1,   8'sd5,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0000, 16'sd3,   16'sd0,   -8'sd1,  -8'sd3,  1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0000, 16'sd0,   16'sd0,   8'sd127, 8'sd0,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0000, 16'sd0,   16'sd0,   8'h80,   8'sd127, 1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'hFFFF, 16'h7FFF, 16'h7FFF, 8'sd0,   8'h80,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'hFFE0, 16'hFFFF, 16'sd200, 8'sd3,   8'h80,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_FAILED, 16'h0000, 16'sd9,   16'sd9,   8'sd5,   8'sd9,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0010, -16'sd300, -16'sd129, 8'sd0, 8'sd0,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0008, 16'sd0,   16'sd0,   8'sd2,   8'sd1,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'h0000, 16'sd0,   16'sd0,   8'sd0,   8'sd0,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_NONE,   16'h5555, 16'h5555, 16'hAAAA, 8'h55,   8'hAA,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00},
            '{ST_VALID,  16'hAAAA, 16'h5555, 16'hAAAA, 8'h55,   8'hAA,   1'b0, 1'b0,
              8'h00, 8'h00, 8'h00}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            offer_report(directed_rows[i]);
        drain_block();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_settings(phase_win[p], phase_div[p], phase_max[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                idx = p * ITEMS_PER_PHASE + k;
                if (idx < 60)
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 52;
                end
                else if (idx < 120)
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 14;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (idx == HOLD_AT)
                    hold_off_req = 1'b1;

                rnd = $urandom_range(0, 99);
                if (rnd < 6)
                    r.status = ST_NONE;
                else if (rnd < 12)
                    r.status = ST_FAILED;
                else if (rnd < 16)
                    r.status = ST_ODD;
                else
                    r.status = ST_VALID;
                case ($urandom_range(0, 3))
                    0:       r.buttons = seen_buttons;
                    1:       r.buttons = seen_buttons ^ (16'd1 << $urandom_range(0, 4));
                    2:       r.buttons = {11'd0, 5'($urandom)};
                    default: r.buttons = 16'($urandom);
                endcase
                r.move_x = pick_motion();
                r.move_y = pick_motion();
                rnd = $urandom_range(0, 99);
                if (rnd < 55)
                    r.wheel = 8'sd0;
                else if (rnd < 85)
                    r.wheel = $urandom_range(0, 1) ? 8'($urandom_range(1, 3))
                                                   : -8'($urandom_range(1, 3));
                else
                    r.wheel = 8'($urandom);
                rnd = $urandom_range(0, 99);
                if (rnd < 50)
                    r.pan = seen_pan;
                else if (rnd < 70)
                    r.pan = 8'sd0;
                else
                    r.pan = 8'($urandom);
                r.typed = 1'b0;
                r.has_packet = 1'b0;
                r.hdr = 8'd0;
                r.dx = 8'd0;
                r.dy = 8'd0;
                offer_report(r);
            end
            drain_block();
        end

        $display("%0d reports sent, %0d events compared over %0d register settings",
                 reports_sent, events_checked, NUM_PHASES + 1);
        $display("covered saver skips, bad status, wheel scaling and cap, pan edges,");
        $display("and a %0d-cycle receiver hold-off", HOLD_OFF_CYCLES);
        if (mismatch_count == 0)
            $display("mouse_report_to_legacy_events: match");
        else
            $display("mouse_report_to_legacy_events: mismatch");
        $finish;
    end

endmodule
